>>> rtl/twbd_pkg.sv
// ----------------------------------------------------------------------------
// twbd_pkg: shared types and constants
// Q-format constants, CORDIC arctangent table and register indexes.
// ----------------------------------------------------------------------------
package twbd_pkg;

   localparam int MAX_STAGES            = 24;
   localparam int CORDIC_STAGES_DEFAULT = 16;

   localparam logic signed [36:0] TWO_PI_Q32      = 37'sd26986075410;
   localparam logic signed [36:0] PI_Q32          = 37'sd13493037705;
   localparam logic signed [36:0] HALF_PI_Q32     = 37'sd6746518852;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   // floor(2^64 / TWO_PI_Q32): quotient estimate for the phase reduction
   localparam logic [29:0]        INV_TWO_PI_Q32  = 30'd683565275;

   // register indexes
   localparam logic [2:0] REG_AMP    = 3'd0;
   localparam logic [2:0] REG_OMEGA  = 3'd1;
   localparam logic [2:0] REG_BLEN   = 3'd2;
   localparam logic [2:0] REG_INVLEN = 3'd3;
   localparam logic [2:0] REG_ORIGIN = 3'd4;
   localparam logic [2:0] REG_AXIS   = 3'd5;
   localparam logic [2:0] REG_WAVE   = 3'd6;

   // one CORDIC cell's data
   typedef struct packed {
      logic              vld;
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } cordic_type;

   function automatic logic signed [33:0] atan_q30(input int i);
      logic signed [33:0] v;
      case (i)
         0:  v = 34'sh3243F6A8;
         1:  v = 34'sh1DAC6705;
         2:  v = 34'sh0FADBAFC;
         3:  v = 34'sh07F56EA6;
         4:  v = 34'sh03FEAB76;
         5:  v = 34'sh01FFD55B;
         6:  v = 34'sh00FFFAAA;
         7:  v = 34'sh007FFF55;
         8:  v = 34'sh003FFFEA;
         9:  v = 34'sh001FFFFD;
         10: v = 34'sh000FFFFF;
         11: v = 34'sh0007FFFF;
         12: v = 34'sh0003FFFF;
         13: v = 34'sh0001FFFF;
         14: v = 34'sh0000FFFF;
         15: v = 34'sh00007FFF;
         16: v = 34'sh00003FFF;
         17: v = 34'sh00001FFF;
         18: v = 34'sh00000FFF;
         19: v = 34'sh000007FF;
         20: v = 34'sh000003FF;
         21: v = 34'sh000001FF;
         22: v = 34'sh000000FF;
         default: v = 34'sh0000007F;
      endcase
      return v;
   endfunction

   // round16 of a product: floor((v + 2^15) / 2^16)
   function automatic logic signed [79:0] rnd16(input logic signed [79:0] v);
      logic signed [79:0] t;
      t = v + 80'sd32768;
      return t >>> 16;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
      logic signed [31:0] r;
      if (v > 80'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -80'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic is_clip(input logic signed [79:0] v);
      return (v > 80'sd2147483647) || (v < -80'sd2147483648);
   endfunction

endpackage

>>> rtl/traveling_wave_body_displacement.sv
// ----------------------------------------------------------------------------
// traveling_wave_body_displacement: prescribed mesh point displacement
// Phase, quadratic envelope, CORDIC sine and axis projection, saturated.
// ----------------------------------------------------------------------------
// One request per clock is accepted while the pipeline advances; each gives
// one response, which passes through the front stages (relative position,
// dot product, phase difference, quotient estimate, remainder, seed), the
// chain of CORDIC cells (capped at 24 cells) and the back arithmetic stages.
// The whole pipeline advances when the output register is empty or being
// taken, so throughput is one point a cycle.
module traveling_wave_body_displacement
   import twbd_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // pos_x, pos_y, pos_z, sim_time
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // disp_x, disp_y, disp_z
   output logic         rsp_tuser,   // saturated
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int NC  = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;
   localparam int ALN = NC; // delay of the envelope side to meet the sine

   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   assign csr_ready = 1'b1;

   // configuration registers
   logic [62:0] amp_ff, origin_ff, axis_ff, wave_ff;
   logic signed [31:0] omega_ff;
   logic [30:0] blen_ff, invl_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff <= '0; origin_ff <= '0; axis_ff <= '0; wave_ff <= '0;
         omega_ff <= '0; blen_ff <= '0; invl_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_AMP:    amp_ff    <= csr_data[62:0];
            REG_OMEGA:  omega_ff  <= csr_data[31:0];
            REG_BLEN:   blen_ff   <= csr_data[30:0];
            REG_INVLEN: invl_ff   <= csr_data[30:0];
            REG_ORIGIN: origin_ff <= csr_data[62:0];
            REG_AXIS:   axis_ff   <= csr_data[62:0];
            REG_WAVE:   wave_ff   <= csr_data[62:0];
            default: ;
         endcase
      end
   end

   function automatic logic signed [20:0] fld(input logic [62:0] p, input int s);
      return p[21*s +: 21];
   endfunction

   // ---- stage 1: relative position, omega*t
   logic v1_ff;
   logic signed [32:0] r_ff [3];
   logic signed [64:0] ot_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
      if (adv) begin
         for (int c = 0; c < 3; c++)
            r_ff[c] <= 33'(signed'(req_tdata[32*c +: 32])) - 33'(fld(origin_ff, c));
         ot_ff <= 65'(omega_ff) * 65'($signed({1'b0, req_tdata[127:96]}));
      end
   end

   // ---- stage 2: dot product terms, xc product
   logic v2_ff;
   logic signed [54:0] kr_ff [3];
   logic signed [64:0] ot2_ff;
   logic signed [79:0] xcp_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         for (int c = 0; c < 3; c++)
            kr_ff[c] <= 55'(fld(wave_ff, c)) * 55'(r_ff[c]);
         ot2_ff <= ot_ff;
         xcp_ff <= 80'($signed({1'b0, invl_ff})) * 80'(r_ff[0]);
      end
   end

   // ---- stage 3: phase difference, xc
   logic v3_ff;
   logic signed [65:0] ph_ff;
   logic signed [31:0] xc_ff;
   logic signed [56:0] dsum;
   assign dsum = 57'(kr_ff[0]) + 57'(kr_ff[1]) + 57'(kr_ff[2]);
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         ph_ff <= 66'(ot2_ff) - 66'(dsum);
         xc_ff <= sat32(rnd16(xcp_ff));
      end
   end

   // ---- quotient estimate: high word times the reciprocal of two pi
   logic v4_ff;
   logic signed [65:0] ph4_ff, qp;
   logic signed [31:0] q_ff;
   assign qp = 66'($signed(ph_ff[65:32])) * 66'($signed({1'b0, INV_TWO_PI_Q32}));
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
      if (adv) begin
         ph4_ff <= ph_ff;
         q_ff   <= 32'(qp >>> 32);
      end
   end

   // ---- remainder after the quotient estimate, brought into range by the fold below
   logic v5_ff;
   logic signed [65:0] qm;
   logic signed [36:0] rem_ff;
   assign qm = 66'(q_ff) * 66'(TWO_PI_Q32);
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) rem_ff <= 37'(ph4_ff - qm);
   end

   // ---- bring phase to [-pi/2, pi/2], seed CORDIC
   logic signed [38:0] a0, a1, a2;
   cordic_type seed, seed_ff;
   always_comb begin
      a0 = 39'(rem_ff);
      if (a0 < 0) a0 = a0 + 39'(TWO_PI_Q32);
      if (a0 >= 39'(TWO_PI_Q32)) a0 = a0 - 39'(TWO_PI_Q32);
      a1 = (a0 >= 39'(PI_Q32)) ? a0 - 39'(TWO_PI_Q32) : a0;
      if (a1 > 39'(HALF_PI_Q32)) a2 = 39'(PI_Q32) - a1;
      else if (a1 < -39'(HALF_PI_Q32)) a2 = -39'(PI_Q32) - a1;
      else a2 = a1;
      seed.vld = v5_ff;
      seed.x = CORDIC_GAIN_Q30;
      seed.y = '0;
      seed.z = 34'(a2 >>> 2);
   end
   cordic_type chain [NC+1];
   always_ff @(posedge clock) begin
      if (reset) seed_ff.vld <= 1'b0;
      else if (adv) seed_ff.vld <= seed.vld;
      if (adv) begin
         seed_ff.x <= seed.x; seed_ff.y <= seed.y; seed_ff.z <= seed.z;
      end
   end
   assign chain[0] = seed_ff;

   // envelope side: square then envelope, then delay line
   logic signed [31:0] xc4_ff;
   logic signed [79:0] sqp_ff;
   always_ff @(posedge clock) if (adv) begin
      xc4_ff <= xc_ff;
      sqp_ff <= 80'(xc_ff) * 80'(xc_ff);
   end

   genvar g;
   generate
      for (g = 0; g < NC; g++) begin : g_cell
         twbd_cordic_cell #(.STAGE(g)) u_cell (
            .clock(clock), .reset(reset), .enable(adv),
            .cell_in(chain[g]), .cell_out(chain[g+1]));
      end
   endgenerate

   logic signed [31:0] sq5_ff, xc5_ff;
   always_ff @(posedge clock) if (adv) begin
      sq5_ff <= sat32(rnd16(sqp_ff));
      xc5_ff <= xc4_ff;
   end
   logic signed [79:0] t1_ff, t2_ff;
   always_ff @(posedge clock) if (adv) begin
      t1_ff <= 80'(fld(amp_ff, 1)) * 80'(xc5_ff);
      t2_ff <= 80'(fld(amp_ff, 2)) * 80'(sq5_ff);
   end
   logic signed [31:0] env_dl [ALN];
   always_ff @(posedge clock) if (adv) begin
      env_dl[0] <= sat32(80'(fld(amp_ff, 0)) + rnd16(t1_ff) + rnd16(t2_ff));
      for (int k = 1; k < ALN; k++) env_dl[k] <= env_dl[k-1];
   end

   // ---- back end: sine, products, projection
   logic signed [33:0] ysum;
   assign ysum = chain[NC].y + 34'sd8192;
   logic vb1_ff, vb2_ff, vb3_ff, vb4_ff, vb5_ff, vb6_ff;
   logic signed [31:0] env_b_ff, w_ff;
   logic signed [19:0] s_ff;
   logic signed [79:0] wp_ff, mp_ff;
   logic signed [47:0] m_ff;
   logic signed [79:0] dp_ff [3];
   always_ff @(posedge clock) begin
      if (reset) begin
         vb1_ff <= 1'b0; vb2_ff <= 1'b0; vb3_ff <= 1'b0;
         vb4_ff <= 1'b0; vb5_ff <= 1'b0; vb6_ff <= 1'b0;
      end else if (adv) begin
         vb1_ff <= chain[NC].vld; vb2_ff <= vb1_ff; vb3_ff <= vb2_ff;
         vb4_ff <= vb3_ff; vb5_ff <= vb4_ff; vb6_ff <= vb5_ff;
      end
      if (adv) begin
         s_ff     <= 20'(ysum >>> 14);
         env_b_ff <= env_dl[ALN-1];
         wp_ff    <= 80'(env_b_ff) * 80'(s_ff);
         w_ff     <= sat32(rnd16(wp_ff));
         mp_ff    <= 80'($signed({1'b0, blen_ff})) * 80'(w_ff);
         m_ff     <= 48'(rnd16(mp_ff));
         for (int c = 0; c < 3; c++)
            dp_ff[c] <= 80'(fld(axis_ff, c)) * 80'(m_ff);
      end
   end

   // output register
   logic [95:0] out_d_ff;
   logic out_s_ff, out_v_ff;
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= vb6_ff;
      if (adv) begin
         for (int c = 0; c < 3; c++)
            out_d_ff[32*c +: 32] <= sat32(rnd16(dp_ff[c]));
         out_s_ff <= is_clip(rnd16(dp_ff[0])) | is_clip(rnd16(dp_ff[1]))
                   | is_clip(rnd16(dp_ff[2]));
      end
   end
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;
   assign rsp_tuser  = out_s_ff;

`ifndef NO_ASSERTIONS
   // a stalled response holds its data
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");
   // request side is ready whenever the output is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipeline stalled with empty output");
`endif

endmodule

>>> rtl/twbd_cordic_cell.sv
// ----------------------------------------------------------------------------
// twbd_cordic_cell: one CORDIC rotation cell
// Rotates by +/- atan(2^-STAGE) and hands the vector to the next cell.
// ----------------------------------------------------------------------------
module twbd_cordic_cell
   import twbd_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  cordic_type cell_in,
   output cordic_type cell_out
);

   cordic_type cell_ff, cell_in_nx;
   logic signed [33:0] dx, dy;

   // rotate toward zero residual angle
   always_comb begin
      dx = cell_in.y >>> STAGE;
      dy = cell_in.x >>> STAGE;
      cell_in_nx = cell_in;
      if (!cell_in.z[33]) begin
         cell_in_nx.x = cell_in.x - dx;
         cell_in_nx.y = cell_in.y + dy;
         cell_in_nx.z = cell_in.z - atan_q30(STAGE);
      end else begin
         cell_in_nx.x = cell_in.x + dx;
         cell_in_nx.y = cell_in.y - dy;
         cell_in_nx.z = cell_in.z + atan_q30(STAGE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (enable) begin
         cell_ff.vld <= cell_in_nx.vld;
      end
      if (enable) begin
         cell_ff.x <= cell_in_nx.x;
         cell_ff.y <= cell_in_nx.y;
         cell_ff.z <= cell_in_nx.z;
      end
   end

   assign cell_out = cell_ff;

endmodule
